// ===== src/fbm_pkg.sv =====
// ----------------------------------------------------------------------------
// fbm_pkg: shared types and constants for the fsk bitstream modulator
// Command codes, register indexes, the per-tick control word passed from the
// sequencer to the oscillator stage, and the int8 sine lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package fbm_pkg;

  // bit store geometry (power of two)
  localparam int STORE_BYTES = 512;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  // phase step per hertz of deviation
  localparam logic [10:0] STEP_PER_HZ = 11'd1883;

  // quarter turn added to the phase index for the cosine output
  localparam logic [7:0] QUARTER_IDX = 8'h40;

  // input commands (code 3 is ignored)
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_BIT_PERIOD      = 2'd0,
    REG_PAYLOAD_BITS    = 2'd1,
    REG_SHIFT_HZ        = 2'd2,
    REG_NOTICE_INTERVAL = 2'd3
  } reg_idx_t;

  // per-tick control word from the sequencer to the oscillator stage
  typedef struct packed {
    logic        run;       // block was armed when the tick arrived
    logic        fetch;     // bit boundary with a fresh bit from the store
    logic        ends;      // bit boundary that ends the run
    logic        clr;       // first tick since start: bit starts at zero
    logic [2:0]  boff;      // bit position within the fetched byte
    logic [12:0] progress;  // progress total after this tick
    logic        pev;       // progress event
    logic        dev;       // done event
    logic        active;    // still armed after this tick
  } tick_t;

  // first quadrant of the sine, 65 points, magnitude 0..127
  localparam logic [6:0] QSINE [65] = '{
    7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd16,  7'd19,  7'd22,
    7'd25,  7'd28,  7'd31,  7'd34,  7'd37,  7'd40,  7'd43,  7'd46,
    7'd49,  7'd51,  7'd54,  7'd57,  7'd60,  7'd63,  7'd65,  7'd68,
    7'd71,  7'd73,  7'd76,  7'd78,  7'd81,  7'd83,  7'd85,  7'd88,
    7'd90,  7'd92,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd104,
    7'd106, 7'd107, 7'd109, 7'd111, 7'd112, 7'd113, 7'd115, 7'd116,
    7'd117, 7'd118, 7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124,
    7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd127, 7'd127, 7'd127,
    7'd127
  };

  // int8 sine of an 8-bit phase, folded from the quarter table
  function automatic logic [7:0] sine8(input logic [7:0] ph);
    logic [7:0] q;
    logic [7:0] idx;
    logic [6:0] mag;
    q   = {1'b0, ph[6:0]};
    idx = (q <= 8'd64) ? q : (8'd128 - q);
    mag = QSINE[idx[6:0]];
    if (ph[7]) begin
      sine8 = 8'd0 - {1'b0, mag};
    end else begin
      sine8 = {1'b0, mag};
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/fbm_store.sv =====
// ----------------------------------------------------------------------------
// fbm_store: bit store memory
// One write port, one read port with enable, read data registered.
// Contents are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module fbm_store (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [fbm_pkg::ADDR_W-1:0] waddr,
  input  wire logic [7:0]                wdata,
  input  wire logic                      re,
  input  wire logic [fbm_pkg::ADDR_W-1:0] raddr,
  output logic      [7:0]                rdata
);
  import fbm_pkg::*;

  logic [7:0] mem [STORE_BYTES];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/fbm_ctrl.sv =====
// ----------------------------------------------------------------------------
// fbm_ctrl: command decode and bit sequencer
// Holds the configuration registers, bit timer, bit index and progress
// counters; issues store writes for loads and store reads at bit boundaries.
// ----------------------------------------------------------------------------
`default_nettype none

module fbm_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // input stream
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [23:0]                s_tdata,
  input  wire logic [1:0]                 s_tuser,
  // configuration
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [19:0]                cfg_data,
  // to oscillator stage
  input  wire logic                       pipe_ready,
  output logic                            tick_valid,
  output fbm_pkg::tick_t                  tick,
  output logic      [31:0]                step,
  // bit store
  output logic                            st_we,
  output logic      [fbm_pkg::ADDR_W-1:0] st_waddr,
  output logic      [7:0]                 st_wdata,
  output logic                            st_re,
  output logic      [fbm_pkg::ADDR_W-1:0] st_raddr
);
  import fbm_pkg::*;

  logic [15:0] bit_period;
  logic [11:0] payload_bits;
  logic [19:0] shift_hz;
  logic [11:0] notice_interval;

  logic [15:0] sample_counter, sample_counter_next;
  logic [12:0] bit_index, bit_index_next;
  logic [11:0] notice_counter, notice_counter_next;
  logic [12:0] progress_total, progress_total_next;
  logic        running, running_next;
  logic        clr_pend, clr_pend_next;

  logic        accept;
  cmd_t        cmd;
  logic [8:0]  byte_address;
  logic [7:0]  byte_value;
  logic [31:0] addr_ext;
  logic [31:0] byte_idx;
  logic [12:0] last_index;
  logic [30:0] step_prod;

  assign cfg_ready    = 1'b1;
  assign s_tready     = pipe_ready;
  assign accept       = s_tvalid && pipe_ready;
  assign cmd          = cmd_t'(s_tuser);
  assign byte_address = s_tdata[8:0];
  assign byte_value   = s_tdata[16:9];
  assign addr_ext     = {23'd0, byte_address};
  assign byte_idx     = {19'd0, bit_index} >> 3;
  assign last_index   = {1'b0, payload_bits} + 13'd32;
  assign step_prod    = {11'd0, shift_hz} * {20'd0, STEP_PER_HZ};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period      <= '0;
      payload_bits    <= '0;
      shift_hz        <= '0;
      notice_interval <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BIT_PERIOD:      bit_period      <= cfg_data[15:0];
        REG_PAYLOAD_BITS:    payload_bits    <= cfg_data[11:0];
        REG_SHIFT_HZ:        shift_hz        <= cfg_data;
        REG_NOTICE_INTERVAL: notice_interval <= cfg_data[11:0];
        default:             ;
      endcase
    end
  end

  // phase step, registered off the multiplier
  always_ff @(posedge clk) begin
    step <= {1'b0, step_prod};
  end

  // store write for loads
  assign st_we    = accept && (cmd == CMD_LOAD) && (addr_ext < 32'(STORE_BYTES));
  assign st_waddr = addr_ext[ADDR_W-1:0];
  assign st_wdata = byte_value;
  assign st_raddr = byte_idx[ADDR_W-1:0];

  // sequencer next state and tick word
  always_comb begin
    sample_counter_next = sample_counter;
    bit_index_next      = bit_index;
    notice_counter_next = notice_counter;
    progress_total_next = progress_total;
    running_next        = running;
    clr_pend_next       = clr_pend;
    tick_valid          = 1'b0;
    st_re               = 1'b0;
    tick                = '0;
    tick.boff           = bit_index[2:0];
    if (accept) begin
      unique case (cmd)
        CMD_START: begin
          sample_counter_next = bit_period;
          bit_index_next      = '0;
          notice_counter_next = '0;
          progress_total_next = '0;
          running_next        = 1'b1;
          clr_pend_next       = 1'b1;
        end
        CMD_TICK: begin
          tick_valid    = 1'b1;
          clr_pend_next = 1'b0;
          tick.run      = running;
          tick.clr      = clr_pend;
          if (running) begin
            if (sample_counter >= bit_period) begin
              sample_counter_next = '0;
              if (bit_index > last_index) begin
                tick.ends    = 1'b1;
                tick.dev     = 1'b1;
                running_next = 1'b0;
              end else begin
                tick.fetch     = 1'b1;
                st_re          = 1'b1;
                bit_index_next = bit_index + 13'd1;
                if (notice_counter >= notice_interval) begin
                  notice_counter_next = '0;
                  progress_total_next = progress_total + 13'd1;
                  tick.pev            = 1'b1;
                end else begin
                  notice_counter_next = notice_counter + 12'd1;
                end
              end
            end else begin
              sample_counter_next = sample_counter + 16'd1;
            end
          end
          tick.progress = progress_total_next;
          tick.active   = running_next;
        end
        default: ;
      endcase
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter <= '0;
      bit_index      <= '0;
      notice_counter <= '0;
      progress_total <= '0;
      running        <= 1'b0;
      clr_pend       <= 1'b0;
    end else begin
      sample_counter <= sample_counter_next;
      bit_index      <= bit_index_next;
      notice_counter <= notice_counter_next;
      progress_total <= progress_total_next;
      running        <= running_next;
      clr_pend       <= clr_pend_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/fbm_nco.sv =====
// ----------------------------------------------------------------------------
// fbm_nco: bit select, phase accumulator and sample output
// Takes the tick word together with the store read data, steps the phase
// up or down by the current bit and registers the iq result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module fbm_nco (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           tick_valid,
  input  wire fbm_pkg::tick_t tick,
  input  wire logic [7:0]     rdata,
  input  wire logic [31:0]    step,
  output logic                pipe_ready,
  // output stream
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic      [31:0]    m_tdata,
  output logic      [2:0]     m_tuser
);
  import fbm_pkg::*;

  logic        s1_valid;
  tick_t       s1;
  logic        advance;
  logic [31:0] phase_acc, phase_next;
  logic        current_bit, bit_next;
  logic [7:0]  i_next, q_next;

  assign advance    = s1_valid && (!m_tvalid || m_tready);
  assign pipe_ready = !s1_valid || advance;

  // tick word waits here for the store read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick_valid && pipe_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && pipe_ready) begin
      s1 <= tick;
    end
  end

  // bit select and phase step
  always_comb begin
    bit_next = current_bit;
    priority if (!s1.run) begin
      bit_next = current_bit;
    end else if (s1.ends) begin
      bit_next = 1'b0;
    end else if (s1.fetch) begin
      bit_next = rdata[3'd7 - s1.boff];
    end else if (s1.clr) begin
      bit_next = 1'b0;
    end else begin
      bit_next = current_bit;
    end
    phase_next = phase_acc;
    if (s1.run) begin
      phase_next = bit_next ? (phase_acc + step) : (phase_acc - step);
    end
    i_next = s1.run ? sine8(phase_next[31:24] + QUARTER_IDX) : 8'd0;
    q_next = s1.run ? sine8(phase_next[31:24]) : 8'd0;
  end

  // oscillator state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc   <= '0;
      current_bit <= 1'b0;
    end else if (advance) begin
      phase_acc   <= phase_next;
      current_bit <= bit_next;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {3'd0, s1.progress, q_next, i_next};
      m_tuser <= {s1.active, s1.dev, s1.pev};
    end
  end

endmodule

`default_nettype wire

// ===== src/fsk_bitstream_modulator.sv =====
// An accepted tick beat passes the tick register, then the result register.
// Throughput: one input beat per cycle unless m_tready stalls the result
// beat; the store read and the phase update each take one register stage,
// so ticks stream back to back. Loads and starts produce no result beat.
// Reset (rst, synchronous): counters, phase and handshake state cleared;
// the bit store is not cleared and holds undefined data until loaded.
// ----------------------------------------------------------------------------
// fsk_bitstream_modulator: binary fsk transmitter top level
// Bit store memory, bit sequencer and nco output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fsk_bitstream_modulator (
  input  wire logic        clk,
  input  wire logic        rst,
  // input beat
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // byte_address[8:0], byte_value[16:9]
  input  wire logic [1:0]  s_tuser,   // command[1:0]
  // result beat
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // i_sample[7:0], q_sample[15:8], progress[28:16]
  output logic      [2:0]  m_tuser,   // progress_event[0], done_event[1], active[2]
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);
  import fbm_pkg::*;

  logic              pipe_ready;
  logic              tick_valid;
  tick_t             tick;
  logic [31:0]       step;
  logic              st_we;
  logic [ADDR_W-1:0] st_waddr;
  logic [7:0]        st_wdata;
  logic              st_re;
  logic [ADDR_W-1:0] st_raddr;
  logic [7:0]        st_rdata;

  // bit sequencer
  fbm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pipe_ready (pipe_ready),
    .tick_valid (tick_valid),
    .tick       (tick),
    .step       (step),
    .st_we      (st_we),
    .st_waddr   (st_waddr),
    .st_wdata   (st_wdata),
    .st_re      (st_re),
    .st_raddr   (st_raddr)
  );

  // bit store
  fbm_store u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // oscillator and output stage
  fbm_nco u_nco (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick       (tick),
    .rdata      (st_rdata),
    .step       (step),
    .pipe_ready (pipe_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

`default_nettype wire

// ===== src/fbm_checker.sv =====
// ----------------------------------------------------------------------------
// fbm_checker: port-level checks for the fsk bitstream modulator
// Watches the result stream and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fbm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [2:0]  m_tuser
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // the ending tick leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[2] && !m_tuser[0])
    else $error("done beat still active or with progress event");

  // idle ticks carry zero samples
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[2] && !m_tuser[1] |-> m_tdata[15:0] == 16'd0)
    else $error("idle tick with nonzero samples");

  // a progress event only happens mid-run
  a_pev_active: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tuser[2])
    else $error("progress event while idle");

  // nothing is presented right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result beat right after reset");

endmodule

bind fsk_bitstream_modulator fbm_checker u_fbm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the fsk bitstream modulator
// Fills the bit store, then runs transmissions under several register
// settings and handshake pressure patterns. Every tick beat is predicted by
// a scoreboard that tracks the bit timer, the nco phase and the progress
// and done events, and each result beat is compared field by field.
// ----------------------------------------------------------------------------

module tb_top;
  import fbm_pkg::*;

  localparam int CLK_LIMIT   = 400000;
  localparam int ITEM_TARGET = 1650;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE      = 8;

  // the block ignores this command code
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // first quadrant of the int8 sine, magnitudes at 0..64 of 256 steps
  localparam bit [6:0] QUARTER_SINE [65] = '{
    7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd16,  7'd19,  7'd22,
    7'd25,  7'd28,  7'd31,  7'd34,  7'd37,  7'd40,  7'd43,  7'd46,
    7'd49,  7'd51,  7'd54,  7'd57,  7'd60,  7'd63,  7'd65,  7'd68,
    7'd71,  7'd73,  7'd76,  7'd78,  7'd81,  7'd83,  7'd85,  7'd88,
    7'd90,  7'd92,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd104,
    7'd106, 7'd107, 7'd109, 7'd111, 7'd112, 7'd113, 7'd115, 7'd116,
    7'd117, 7'd118, 7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124,
    7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd127, 7'd127, 7'd127,
    7'd127
  };

  typedef struct packed {
    bit [7:0]  i_samp;
    bit [7:0]  q_samp;
    bit [12:0] progress;
    bit        prog_ev;
    bit        done_ev;
    bit        active;
  } iq_result_t;

  // tracks the modulator and checks its sample beats
  class iq_scoreboard;
    iq_result_t pending_samples[$];
    int errors;

    bit [15:0] bit_period;
    bit [11:0] payload_bits;
    bit [19:0] shift_hz;
    bit [11:0] notice_interval;

    bit [7:0]  bit_store [STORE_BYTES];
    bit [31:0] phase_acc;
    bit [15:0] sample_counter;
    bit [12:0] bit_index;
    bit [11:0] notice_counter;
    bit [12:0] progress_total;
    bit        current_bit;
    bit        running;

    function void write_reg(reg_idx_t idx, bit [19:0] value);
      case (idx)
        REG_BIT_PERIOD:      bit_period      = value[15:0];
        REG_PAYLOAD_BITS:    payload_bits    = value[11:0];
        REG_SHIFT_HZ:        shift_hz        = value;
        REG_NOTICE_INTERVAL: notice_interval = value[11:0];
        default: ;
      endcase
    endfunction

    function bit [7:0] sine_of(bit [7:0] ph);
      bit [6:0] q;
      bit [6:0] mag;
      q   = ph[6:0];
      mag = (q <= 7'd64) ? QUARTER_SINE[q] : QUARTER_SINE[128 - int'(q)];
      return ph[7] ? (8'd0 - {1'b0, mag}) : {1'b0, mag};
    endfunction

    // advance the model by one accepted input beat
    function void accept_beat(bit [1:0] cmd, bit [8:0] addr, bit [7:0] value);
      iq_result_t want;
      bit [7:0]   store_byte;
      bit [31:0]  phase_step;
      case (cmd)
        CMD_LOAD: bit_store[addr] = value;
        CMD_START: begin
          sample_counter = bit_period;
          bit_index      = '0;
          notice_counter = '0;
          progress_total = '0;
          current_bit    = 1'b0;
          running        = 1'b1;
        end
        CMD_TICK: begin
          want = '0;
          if (running) begin
            // bit boundary: fetch the next bit or end the run
            if (sample_counter >= bit_period) begin
              if (int'(bit_index) > int'(payload_bits) + 32) begin
                current_bit  = 1'b0;
                want.done_ev = 1'b1;
                running      = 1'b0;
              end else begin
                store_byte  = bit_store[bit_index[11:3]];
                current_bit = store_byte[3'd7 - bit_index[2:0]];
                bit_index   = bit_index + 13'd1;
                if (notice_counter >= notice_interval) begin
                  notice_counter = '0;
                  progress_total = progress_total + 13'd1;
                  want.prog_ev   = 1'b1;
                end else begin
                  notice_counter = notice_counter + 12'd1;
                end
              end
              sample_counter = '0;
            end else begin
              sample_counter = sample_counter + 16'd1;
            end
            // nco: step up for a one, down for a zero
            phase_step = 32'(shift_hz) * 32'(STEP_PER_HZ);
            phase_acc  = current_bit ? phase_acc + phase_step : phase_acc - phase_step;
            want.i_samp = sine_of(phase_acc[31:24] + QUARTER_IDX);
            want.q_samp = sine_of(phase_acc[31:24]);
          end
          want.progress = progress_total;
          want.active   = running;
          pending_samples.push_back(want);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_sample(iq_result_t got);
      iq_result_t want;
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected result beat, expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_samples.pop_front();
      compare_field("i_sample", int'($signed(want.i_samp)), int'($signed(got.i_samp)));
      compare_field("q_sample", int'($signed(want.q_samp)), int'($signed(got.q_samp)));
      compare_field("progress", want.progress, got.progress);
      compare_field("progress_event", want.prog_ev, got.prog_ev);
      compare_field("done_event", want.done_ev, got.done_ev);
      compare_field("active", want.active, got.active);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  iq_scoreboard sb;
  int items_sent    = 0;
  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;

  fsk_bitstream_modulator uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // result side: check each beat, then pick the next ready
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        sb.check_sample('{i_samp: m_tdata[7:0], q_samp: m_tdata[15:8],
                          progress: m_tdata[28:16], prog_ev: m_tuser[0],
                          done_ev: m_tuser[1], active: m_tuser[2]});
      end
      if (holds_served < hold_requests) begin
        hold_left = HOLD_CYCLES;
        holds_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // one input beat, with a random gap ahead of it
  task automatic send_beat(input logic [1:0] cmd, input logic [8:0] addr,
                           input logic [7:0] value);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {7'd0, value, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.accept_beat(cmd, addr, value);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic send_random(input logic [1:0] cmd);
    send_beat(cmd, 9'($urandom), 8'($urandom));
  endtask

  // sender stops until every sample beat is back, then the block settles
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_reg(input reg_idx_t idx, input logic [19:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic write_regs(input logic [15:0] bp, input logic [11:0] len,
                            input logic [19:0] shift, input logic [11:0] notice);
    put_reg(REG_BIT_PERIOD, {4'd0, bp});
    put_reg(REG_PAYLOAD_BITS, {8'd0, len});
    put_reg(REG_SHIFT_HZ, shift);
    put_reg(REG_NOTICE_INTERVAL, {8'd0, notice});
    cfg_valid <= 1'b0;
  endtask

  // start, then ticks up to done (or a slice of a long run) with some noise
  task automatic run_transmission();
    int run_ticks;
    int n;
    int r;
    run_ticks = (int'(sb.payload_bits) + 33) * (int'(sb.bit_period) + 1) + 1;
    if (run_ticks > 150) begin
      n = $urandom_range(10, 60);
    end else if ($urandom_range(0, 99) < 20) begin
      n = $urandom_range(1, run_ticks);
    end else begin
      n = run_ticks + $urandom_range(0, 3);
    end
    send_random(CMD_START);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 3) send_random(CMD_LOAD);
      else if (r < 5) send_random(CMD_UNUSED);
      else if (r < 6) send_random(CMD_START);
      else send_random(CMD_TICK);
    end
  endtask

  task automatic run_phase(input int budget);
    int goal;
    int r;
    goal = items_sent + budget;
    while (items_sent < goal) begin
      if ($urandom_range(0, 99) < 85) begin
        run_transmission();
      end else begin
        // loose beats of any kind
        repeat ($urandom_range(1, 6)) begin
          r = $urandom_range(0, 99);
          if (r < 50) send_random(CMD_LOAD);
          else if (r < 80) send_random(CMD_TICK);
          else if (r < 90) send_random(CMD_START);
          else send_random(CMD_UNUSED);
        end
      end
    end
  endtask

  // watchdog
  initial begin
    repeat (CLK_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int a;
    int p;
    sb = new;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // tick before any start, then an unknown command
    send_random(CMD_TICK);
    send_random(CMD_UNUSED);

    // fill the whole store so no run reads an unwritten byte
    for (a = 0; a < STORE_BYTES; a++) begin
      send_beat(CMD_LOAD, 9'(a), (a == 0) ? 8'hFF : (a == 1) ? 8'h00 : 8'($urandom));
    end

    // reset registers: run to done and tick past it, then restart mid-run
    send_random(CMD_START);
    repeat (36) send_random(CMD_TICK);
    send_random(CMD_START);
    repeat (3) send_random(CMD_TICK);
    send_random(CMD_START);
    repeat (2) send_random(CMD_TICK);
    drain();

    for (p = 0; items_sent < ITEM_TARGET; p++) begin
      case (p)
        0: write_regs(16'd0, 12'd0, 20'd1000000, 12'd0);
        1: write_regs(16'd2, 12'($urandom_range(0, 12)), 20'($urandom_range(0, 1000000)),
                      12'd3);
        2: write_regs(16'hFFFF, 12'd4063, 20'($urandom_range(0, 1000000)), 12'd4095);
        default: write_regs(16'($urandom_range(0, 3)), 12'($urandom_range(0, 40)),
                            20'($urandom_range(0, 1000000)),
                            12'($urandom_range(0, 12)));
      endcase

      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase

      // long receiver hold while ticks keep coming
      if (p == 2 || p == 4) begin
        hold_requests++;
        send_random(CMD_START);
        repeat (40) send_random(CMD_TICK);
      end

      run_phase((p == 2) ? 40 : 90);
      drain();
      run_phase((p == 2) ? 40 : 90);
      drain();
    end

    if (sb.errors == 0 && sb.pending_samples.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/fbm_pkg.sv
src/fbm_store.sv
src/fbm_ctrl.sv
src/fbm_nco.sv
src/fsk_bitstream_modulator.sv
src/fbm_checker.sv
test/tb_top.sv
